>>> hw/rtl/x86_16bit_instruction_decoder_core_assert.svh
// ----------------------------------------------------------------------------
// x86 decoder assertion macros
// Concurrent assertion wrappers used by the decoder core rtl; compiled out
// when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef X86_16BIT_INSTRUCTION_DECODER_CORE_ASSERT_SVH
`define X86_16BIT_INSTRUCTION_DECODER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// property checked on every rising clock edge outside reset
`define X86DEC_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("x86 decoder assertion failed");

// property checked on every rising clock edge, reset included
`define X86DEC_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) (prop)) \
      else $error("x86 decoder assertion failed");

`else

`define X86DEC_ASSERT(lbl, clk, rst, prop)

`define X86DEC_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

>>> hw/rtl/x86dec_pkg.sv
// ----------------------------------------------------------------------------
// x86dec_pkg
// Shared constants, opcode patterns and types of the 16-bit x86 decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package x86dec_pkg;

   localparam int WINDOW_W = 48;

   // operand kinds
   localparam logic [2:0] KIND_NONE = 3'd0;
   localparam logic [2:0] KIND_REG  = 3'd1;
   localparam logic [2:0] KIND_MEM  = 3'd2;
   localparam logic [2:0] KIND_IMM  = 3'd3;
   localparam logic [2:0] KIND_REL  = 3'd4;

   // operation codes
   localparam logic [4:0] OP_MOV      = 5'd0;
   localparam logic [4:0] OP_ADD      = 5'd1;
   localparam logic [4:0] OP_SUB      = 5'd2;
   localparam logic [4:0] OP_CMP      = 5'd3;
   localparam logic [4:0] OP_JCC_BASE = 5'd4;
   localparam logic [4:0] OP_LOOP     = 5'd20;
   localparam logic [4:0] OP_LOOPZ    = 5'd21;
   localparam logic [4:0] OP_LOOPNZ   = 5'd22;
   localparam logic [4:0] OP_JCXZ     = 5'd23;

   // selector for a direct 16-bit address
   localparam logic [3:0] SEL_DIRECT = 4'd8;
   localparam logic [3:0] SEL_ACC    = 4'd0;

   // displacement sizes
   localparam logic [1:0] DSIZE_NONE = 2'd0;
   localparam logic [1:0] DSIZE_8    = 2'd1;
   localparam logic [1:0] DSIZE_16   = 2'd2;

   // modrm mode field
   localparam logic [1:0] MOD_NODISP = 2'b00;
   localparam logic [1:0] MOD_DISP8  = 2'b01;
   localparam logic [1:0] MOD_DISP16 = 2'b10;
   localparam logic [1:0] MOD_REG    = 2'b11;
   localparam logic [2:0] RM_DIRECT  = 3'b110;

   // first byte patterns
   localparam logic [5:0] PAT_RM_MOV     = 6'b100010;
   localparam logic [5:0] PAT_RM_ADD     = 6'b000000;
   localparam logic [5:0] PAT_RM_SUB     = 6'b001010;
   localparam logic [5:0] PAT_RM_CMP     = 6'b001110;
   localparam logic [6:0] PAT_IMM_MOV    = 7'b1100011;
   localparam logic [5:0] PAT_IMM_GRP    = 6'b100000;
   localparam logic [3:0] PAT_MOV_REG    = 4'b1011;
   localparam logic [6:0] PAT_MOV_ACC_LD = 7'b1010000;
   localparam logic [6:0] PAT_MOV_ACC_ST = 7'b1010001;
   localparam logic [6:0] PAT_ACC_ADD    = 7'b0000010;
   localparam logic [6:0] PAT_ACC_SUB    = 7'b0010110;
   localparam logic [6:0] PAT_ACC_CMP    = 7'b0011110;
   localparam logic [3:0] PAT_JCC        = 4'b0111;
   localparam logic [5:0] PAT_LOOP       = 6'b111000;
   localparam logic [7:0] OPC_LOOP       = 8'hE2;
   localparam logic [7:0] OPC_LOOPZ      = 8'hE1;
   localparam logic [7:0] OPC_LOOPNZ     = 8'hE0;

   // reg field of the immediate group
   localparam logic [2:0] GRP_ADD = 3'd0;
   localparam logic [2:0] GRP_SUB = 3'd5;
   localparam logic [2:0] GRP_CMP = 3'd7;

   typedef struct packed {
      logic [2:0]  kind;
      logic [3:0]  sel;
      logic [2:0]  reg_code;
      logic [1:0]  disp_size;
      logic [15:0] disp_value;
   } modrm_info_type;

   function automatic logic [15:0] sext8(input logic [7:0] value);
      return {{8{value[7]}}, value};
   endfunction

endpackage

>>> hw/rtl/x86dec_modrm.sv
// ----------------------------------------------------------------------------
// x86dec_modrm
// Decodes the ModRM byte and the displacement bytes that follow it into
// an operand kind, a selector and a sign-extended displacement.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module x86dec_modrm (
   input  logic [7:0]                 modrm_byte,
   input  logic [7:0]                 disp_lo,
   input  logic [7:0]                 disp_hi,
   output x86dec_pkg::modrm_info_type info
);
   import x86dec_pkg::*;

   logic [1:0] mode;
   logic [2:0] rm;

   assign mode = modrm_byte[7:6];
   assign rm   = modrm_byte[2:0];

   always_comb begin
      info            = '0;
      info.reg_code   = modrm_byte[5:3];
      unique case (mode)
         MOD_REG: begin
            info.kind = KIND_REG;
            info.sel  = {1'b0, rm};
         end
         MOD_NODISP: begin
            info.kind = KIND_MEM;
            if (rm == RM_DIRECT) begin
               // direct address takes the place of the displacement
               info.sel        = SEL_DIRECT;
               info.disp_size  = DSIZE_16;
               info.disp_value = {disp_hi, disp_lo};
            end else begin
               info.sel = {1'b0, rm};
            end
         end
         MOD_DISP8: begin
            info.kind       = KIND_MEM;
            info.sel        = {1'b0, rm};
            info.disp_size  = DSIZE_8;
            info.disp_value = sext8(disp_lo);
         end
         MOD_DISP16: begin
            info.kind       = KIND_MEM;
            info.sel        = {1'b0, rm};
            info.disp_size  = DSIZE_16;
            info.disp_value = {disp_hi, disp_lo};
         end
      endcase
   end

endmodule

>>> hw/rtl/x86_16bit_instruction_decoder_core.sv
// ----------------------------------------------------------------------------
// x86_16bit_instruction_decoder_core
// Stateless decoder for mov, add, sub, cmp, conditional jumps and loops.
// ----------------------------------------------------------------------------
// The block takes one six-byte window per clock and returns one decoded
// item per window, in order. An item passes through these stages in turn:
// the first stage matches the opcode byte against the supported formats,
// the second decodes the ModRM byte, displacement and length, and the
// third picks the immediate or jump offset into the output register.
// Every stage holds its item while the stage behind it is full, so a
// stall on the result side fills the pipe and then stops intake, and one
// item per clock is sustained whenever results are taken every clock.
`timescale 1ns / 1ps

`include "x86_16bit_instruction_decoder_core_assert.svh"

module x86_16bit_instruction_decoder_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [x86dec_pkg::WINDOW_W-1:0]     req_inst_window,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_known,
   output logic [4:0]                          rsp_operation,
   output logic [2:0]                          rsp_inst_length,
   output logic [2:0]                          rsp_dst_kind,
   output logic [3:0]                          rsp_dst_select,
   output logic [2:0]                          rsp_src_kind,
   output logic [3:0]                          rsp_src_select,
   output logic                                rsp_operand_wide,
   output logic [1:0]                          rsp_disp_size,
   output logic signed [15:0]                  rsp_disp_value,
   output logic                                rsp_imm_wide,
   output logic signed [15:0]                  rsp_imm_value
);
   import x86dec_pkg::*;

   typedef enum logic [2:0] {
      FMT_NONE,
      FMT_RM,
      FMT_IMM_RM,
      FMT_MOV_REG_IMM,
      FMT_MOV_ACC,
      FMT_ACC_IMM,
      FMT_JUMP
   } fmt_type;

   typedef enum logic [1:0] {
      IMM_NONE,
      IMM_BYTE,
      IMM_WORD,
      IMM_REL
   } imm_mode_type;

   // ---------------------------------------------------------------- control
   logic s1_valid_ff, s2_valid_ff, rsp_valid_ff;
   logic out_free, s2_free, s1_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s2_free   = !s2_valid_ff || out_free;
   assign s1_free   = !s1_valid_ff || s2_free;
   assign req_ready = s1_free;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_free) begin
            s1_valid_ff <= req_valid;
         end
         if (s2_free) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (out_free) begin
            rsp_valid_ff <= s2_valid_ff;
         end
      end
   end

   // ------------------------------------------------------- stage 1: classify
   logic [7:0]  opc;
   logic [2:0]  grp_reg;
   fmt_type     fmt_in;
   logic [4:0]  operation_in;
   logic        wide_in, immw_in;

   assign opc     = req_inst_window[7:0];
   assign grp_reg = req_inst_window[13:11];

   always_comb begin
      fmt_in       = FMT_NONE;
      operation_in = OP_MOV;
      wide_in      = opc[0];
      immw_in      = opc[0];
      priority if (opc[7:2] == PAT_RM_MOV || opc[7:2] == PAT_RM_ADD ||
                   opc[7:2] == PAT_RM_SUB || opc[7:2] == PAT_RM_CMP) begin
         fmt_in = FMT_RM;
         priority if (opc[7:2] == PAT_RM_MOV) operation_in = OP_MOV;
         else if (opc[7:2] == PAT_RM_ADD)     operation_in = OP_ADD;
         else if (opc[7:2] == PAT_RM_SUB)     operation_in = OP_SUB;
         else                                 operation_in = OP_CMP;
      end else if (opc[7:1] == PAT_IMM_MOV) begin
         fmt_in = FMT_IMM_RM;
      end else if (opc[7:2] == PAT_IMM_GRP &&
                   (grp_reg == GRP_ADD || grp_reg == GRP_SUB || grp_reg == GRP_CMP)) begin
         fmt_in  = FMT_IMM_RM;
         // sign-extend bit shortens the immediate to one byte
         immw_in = opc[0] && !opc[1];
         priority if (grp_reg == GRP_ADD) operation_in = OP_ADD;
         else if (grp_reg == GRP_SUB)     operation_in = OP_SUB;
         else                             operation_in = OP_CMP;
      end else if (opc[7:4] == PAT_MOV_REG) begin
         fmt_in  = FMT_MOV_REG_IMM;
         wide_in = opc[3];
         immw_in = opc[3];
      end else if (opc[7:1] == PAT_MOV_ACC_LD || opc[7:1] == PAT_MOV_ACC_ST) begin
         fmt_in  = FMT_MOV_ACC;
         immw_in = 1'b1;
      end else if (opc[7:1] == PAT_ACC_ADD || opc[7:1] == PAT_ACC_SUB ||
                   opc[7:1] == PAT_ACC_CMP) begin
         fmt_in = FMT_ACC_IMM;
         priority if (opc[7:1] == PAT_ACC_ADD) operation_in = OP_ADD;
         else if (opc[7:1] == PAT_ACC_SUB)     operation_in = OP_SUB;
         else                                  operation_in = OP_CMP;
      end else if (opc[7:4] == PAT_JCC || opc[7:2] == PAT_LOOP) begin
         fmt_in  = FMT_JUMP;
         wide_in = 1'b0;
         immw_in = 1'b0;
         priority if (opc[7:4] == PAT_JCC) operation_in = OP_JCC_BASE + {1'b0, opc[3:0]};
         else if (opc == OPC_LOOP)         operation_in = OP_LOOP;
         else if (opc == OPC_LOOPZ)        operation_in = OP_LOOPZ;
         else if (opc == OPC_LOOPNZ)       operation_in = OP_LOOPNZ;
         else                              operation_in = OP_JCXZ;
      end else begin
         wide_in = 1'b0;
         immw_in = 1'b0;
      end
   end

   logic [WINDOW_W-1:0] s1_window_ff;
   fmt_type             s1_fmt_ff;
   logic [4:0]          s1_operation_ff;
   logic                s1_wide_ff, s1_immw_ff;

   always_ff @(posedge clock) begin
      if (s1_free) begin
         s1_window_ff    <= req_inst_window;
         s1_fmt_ff       <= fmt_in;
         s1_operation_ff <= operation_in;
         s1_wide_ff      <= wide_in;
         s1_immw_ff      <= immw_in;
      end
   end

   // ----------------------------------------------- stage 2: operands, length
   modrm_info_type modrm_info;

   x86dec_modrm u_modrm (
      .modrm_byte (s1_window_ff[15:8]),
      .disp_lo    (s1_window_ff[23:16]),
      .disp_hi    (s1_window_ff[31:24]),
      .info       (modrm_info)
   );

   logic         known_in;
   logic [2:0]   length_in, immpos_in, rm_len;
   logic [2:0]   dkind_in, skind_in;
   logic [3:0]   dsel_in, ssel_in;
   logic [1:0]   dsize_in;
   logic [15:0]  dval_in;
   imm_mode_type immmode_in;
   logic [2:0]   imm_bytes;

   assign rm_len    = 3'd2 + {1'b0, modrm_info.disp_size};
   assign imm_bytes = s1_immw_ff ? 3'd2 : 3'd1;

   always_comb begin
      known_in   = 1'b1;
      length_in  = 3'd1;
      immpos_in  = 3'd1;
      dkind_in   = KIND_NONE;
      dsel_in    = '0;
      skind_in   = KIND_NONE;
      ssel_in    = '0;
      dsize_in   = DSIZE_NONE;
      dval_in    = '0;
      immmode_in = IMM_NONE;
      unique case (s1_fmt_ff)
         FMT_RM: begin
            length_in = rm_len;
            dsize_in  = modrm_info.disp_size;
            dval_in   = modrm_info.disp_value;
            // d bit: register operand is the destination
            if (s1_window_ff[1]) begin
               dkind_in = KIND_REG;
               dsel_in  = {1'b0, modrm_info.reg_code};
               skind_in = modrm_info.kind;
               ssel_in  = modrm_info.sel;
            end else begin
               dkind_in = modrm_info.kind;
               dsel_in  = modrm_info.sel;
               skind_in = KIND_REG;
               ssel_in  = {1'b0, modrm_info.reg_code};
            end
         end
         FMT_IMM_RM: begin
            immpos_in  = rm_len;
            length_in  = rm_len + imm_bytes;
            dkind_in   = modrm_info.kind;
            dsel_in    = modrm_info.sel;
            skind_in   = KIND_IMM;
            dsize_in   = modrm_info.disp_size;
            dval_in    = modrm_info.disp_value;
            immmode_in = s1_immw_ff ? IMM_WORD : IMM_BYTE;
         end
         FMT_MOV_REG_IMM: begin
            length_in  = 3'd1 + imm_bytes;
            dkind_in   = KIND_REG;
            dsel_in    = {1'b0, s1_window_ff[2:0]};
            skind_in   = KIND_IMM;
            immmode_in = s1_immw_ff ? IMM_WORD : IMM_BYTE;
         end
         FMT_MOV_ACC: begin
            length_in  = 3'd3;
            immmode_in = IMM_WORD;
            if (s1_window_ff[1]) begin
               dkind_in = KIND_IMM;
               skind_in = KIND_REG;
               ssel_in  = SEL_ACC;
            end else begin
               dkind_in = KIND_REG;
               dsel_in  = SEL_ACC;
               skind_in = KIND_IMM;
            end
         end
         FMT_ACC_IMM: begin
            length_in  = 3'd1 + imm_bytes;
            dkind_in   = KIND_REG;
            dsel_in    = SEL_ACC;
            skind_in   = KIND_IMM;
            immmode_in = s1_immw_ff ? IMM_WORD : IMM_BYTE;
         end
         FMT_JUMP: begin
            length_in  = 3'd2;
            dkind_in   = KIND_REL;
            immmode_in = IMM_REL;
         end
         FMT_NONE: begin
            known_in = 1'b0;
         end
         default: begin
            known_in = 1'b0;
         end
      endcase
   end

   logic [WINDOW_W-1:0] s2_window_ff;
   logic                s2_known_ff, s2_wide_ff;
   logic [4:0]          s2_operation_ff;
   logic [2:0]          s2_length_ff, s2_immpos_ff, s2_dkind_ff, s2_skind_ff;
   logic [3:0]          s2_dsel_ff, s2_ssel_ff;
   logic [1:0]          s2_dsize_ff;
   logic [15:0]         s2_dval_ff;
   imm_mode_type        s2_immmode_ff;

   always_ff @(posedge clock) begin
      if (s2_free) begin
         s2_window_ff    <= s1_window_ff;
         s2_known_ff     <= known_in;
         s2_operation_ff <= s1_operation_ff;
         s2_wide_ff      <= s1_wide_ff;
         s2_length_ff    <= length_in;
         s2_immpos_ff    <= immpos_in;
         s2_dkind_ff     <= dkind_in;
         s2_dsel_ff      <= dsel_in;
         s2_skind_ff     <= skind_in;
         s2_ssel_ff      <= ssel_in;
         s2_dsize_ff     <= dsize_in;
         s2_dval_ff      <= dval_in;
         s2_immmode_ff   <= immmode_in;
      end
   end

   // -------------------------------------------- stage 3: immediate, output
   logic [15:0] imm_word;
   logic [7:0]  rel_byte;
   logic [15:0] imm_value_in;

   assign imm_word = s2_window_ff[{s2_immpos_ff, 3'b000} +: 16];
   // jump offset is taken relative to the end of the two-byte instruction
   assign rel_byte = s2_window_ff[15:8] + 8'd2;

   always_comb begin
      unique case (s2_immmode_ff)
         IMM_NONE: imm_value_in = '0;
         IMM_BYTE: imm_value_in = sext8(imm_word[7:0]);
         IMM_WORD: imm_value_in = imm_word;
         IMM_REL:  imm_value_in = sext8(rel_byte);
         default:  imm_value_in = '0;
      endcase
   end

   logic        rsp_known_ff, rsp_wide_ff, rsp_immw_ff;
   logic [4:0]  rsp_operation_ff;
   logic [2:0]  rsp_length_ff, rsp_dkind_ff, rsp_skind_ff;
   logic [3:0]  rsp_dsel_ff, rsp_ssel_ff;
   logic [1:0]  rsp_dsize_ff;
   logic [15:0] rsp_dval_ff, rsp_ival_ff;

   always_ff @(posedge clock) begin
      if (out_free) begin
         rsp_known_ff     <= s2_known_ff;
         rsp_operation_ff <= s2_operation_ff;
         rsp_length_ff    <= s2_length_ff;
         rsp_dkind_ff     <= s2_dkind_ff;
         rsp_dsel_ff      <= s2_dsel_ff;
         rsp_skind_ff     <= s2_skind_ff;
         rsp_ssel_ff      <= s2_ssel_ff;
         rsp_wide_ff      <= s2_wide_ff;
         rsp_dsize_ff     <= s2_dsize_ff;
         rsp_dval_ff      <= s2_dval_ff;
         rsp_immw_ff      <= (s2_immmode_ff == IMM_WORD);
         rsp_ival_ff      <= imm_value_in;
      end
   end

   assign rsp_known        = rsp_known_ff;
   assign rsp_operation    = rsp_operation_ff;
   assign rsp_inst_length  = rsp_length_ff;
   assign rsp_dst_kind     = rsp_dkind_ff;
   assign rsp_dst_select   = rsp_dsel_ff;
   assign rsp_src_kind     = rsp_skind_ff;
   assign rsp_src_select   = rsp_ssel_ff;
   assign rsp_operand_wide = rsp_wide_ff;
   assign rsp_disp_size    = rsp_dsize_ff;
   assign rsp_disp_value   = rsp_dval_ff;
   assign rsp_imm_wide     = rsp_immw_ff;
   assign rsp_imm_value    = rsp_ival_ff;

   // ------------------------------------------------------------- assertions
   `X86DEC_ASSERT(a_unknown_is_one_byte, clock, reset,
      rsp_valid_ff && !rsp_known_ff |->
         rsp_length_ff == 3'd1 && rsp_dkind_ff == KIND_NONE && rsp_ival_ff == 16'd0)
   `X86DEC_ASSERT(a_rel_shape, clock, reset,
      rsp_valid_ff && rsp_dkind_ff == KIND_REL |->
         rsp_length_ff == 3'd2 && rsp_skind_ff == KIND_NONE && !rsp_immw_ff)
   `X86DEC_ASSERT(a_no_disp_is_zero, clock, reset,
      rsp_valid_ff && rsp_dsize_ff == DSIZE_NONE |-> rsp_dval_ff == 16'd0)
   `X86DEC_ASSERT(a_stalled_stage_holds, clock, reset,
      s2_valid_ff && !out_free |=> s2_valid_ff && $stable(s2_dval_ff) && $stable(s2_length_ff))
   `X86DEC_ASSERT(a_empty_pipe_ready, clock, reset,
      !s1_valid_ff && !s2_valid_ff && !rsp_valid_ff |-> req_ready)

endmodule

>>> verif/tb_x86_16bit_instruction_decoder_core.sv
// ----------------------------------------------------------------------------
// tb_x86_16bit_instruction_decoder_core
// Self-checking bench for the 8086 instruction decoder. A short list of
// hand-picked windows covers every format, the operand extremes and the
// unknown encodings. Random, mostly well-formed windows follow, under
// random idle gaps on both channels. Each result is compared field by
// field with a typed row's written-out result or an in-bench decode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_x86_16bit_instruction_decoder_core;

   import x86dec_pkg::*;

   localparam int N_DIRECTED   = 26;
   localparam int RANDOM_ITEMS = 524;
   localparam int STALL_LIMIT  = 500;
   localparam int TAIL_CYCLES  = 20;

   typedef struct packed {
      logic        known;
      logic [4:0]  operation;
      logic [2:0]  inst_length;
      logic [2:0]  dst_kind;
      logic [3:0]  dst_select;
      logic [2:0]  src_kind;
      logic [3:0]  src_select;
      logic        operand_wide;
      logic [1:0]  disp_size;
      logic [15:0] disp_value;
      logic        imm_wide;
      logic [15:0] imm_value;
   } decoded_inst_type;

   // one hand-picked window; typed rows carry their result written out
   typedef struct packed {
      logic [WINDOW_W-1:0] window;
      logic                typed;
      decoded_inst_type    want;
   } decode_case_type;

   typedef struct packed {
      logic [WINDOW_W-1:0] window;
      decoded_inst_type    want;
   } pending_decode_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [WINDOW_W-1:0]   req_inst_window;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic                  rsp_known;
   logic [4:0]            rsp_operation;
   logic [2:0]            rsp_inst_length;
   logic [2:0]            rsp_dst_kind;
   logic [3:0]            rsp_dst_select;
   logic [2:0]            rsp_src_kind;
   logic [3:0]            rsp_src_select;
   logic                  rsp_operand_wide;
   logic [1:0]            rsp_disp_size;
   logic signed [15:0]    rsp_disp_value;
   logic                  rsp_imm_wide;
   logic signed [15:0]    rsp_imm_value;

   decode_case_type       decode_cases [N_DIRECTED];
   pending_decode_type    pending_decodes [$];
   int unsigned           windows_sent;
   int unsigned           results_checked;
   int unsigned           unknown_seen;
   int unsigned           mismatches;
   int unsigned           feed_burst;
   int unsigned           drain_burst;
   logic [23:0]           ops_seen;

   x86_16bit_instruction_decoder_core dut (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic decoded_inst_type decoded(
      input logic known, input logic [4:0] operation, input logic [2:0] len,
      input logic [2:0] dk, input logic [3:0] ds, input logic [2:0] sk,
      input logic [3:0] ss, input logic wide, input logic [1:0] dsize,
      input logic [15:0] dval, input logic iwide, input logic [15:0] ival);
      return '{known, operation, len, dk, ds, sk, ss, wide, dsize, dval, iwide, ival};
   endfunction

   // full decode of one window
   function automatic decoded_inst_type decode_inst(input logic [WINDOW_W-1:0] win);
      decoded_inst_type d;
      logic [7:0]    opc;
      logic [1:0]    mode;
      logic [2:0]    regf;
      logic [2:0]    rm;
      logic [2:0]    rm_kind;
      logic [3:0]    rm_sel;
      logic [1:0]    rm_dsize;
      logic [15:0]   rm_disp;
      int unsigned   rm_len;
      logic          imm16;
      int unsigned   imm_pos;
      logic [7:0]    rel;
      d = '0;
      opc = win[7:0];
      mode = win[15:14];
      regf = win[13:11];
      rm = win[10:8];
      rm_kind = KIND_MEM;
      rm_sel = {1'b0, rm};
      rm_dsize = DSIZE_NONE;
      rm_disp = '0;
      rm_len = 2;
      case (mode)
         MOD_REG: begin
            rm_kind = KIND_REG;
         end
         MOD_DISP8: begin
            rm_dsize = DSIZE_8;
            rm_disp = {{8{win[23]}}, win[23:16]};
            rm_len = 3;
         end
         MOD_DISP16: begin
            rm_dsize = DSIZE_16;
            rm_disp = win[31:16];
            rm_len = 4;
         end
         MOD_NODISP: begin
            if (rm == RM_DIRECT) begin
               rm_sel = SEL_DIRECT;
               rm_dsize = DSIZE_16;
               rm_disp = win[31:16];
               rm_len = 4;
            end
         end
      endcase
      d.known = 1'b1;
      imm16 = 1'b0;
      imm_pos = 0;
      if (opc[7:2] == PAT_RM_MOV || opc[7:2] == PAT_RM_ADD || opc[7:2] == PAT_RM_SUB ||
          opc[7:2] == PAT_RM_CMP) begin
         case (opc[7:2])
            PAT_RM_MOV: d.operation = OP_MOV;
            PAT_RM_ADD: d.operation = OP_ADD;
            PAT_RM_SUB: d.operation = OP_SUB;
            default:    d.operation = OP_CMP;
         endcase
         d.inst_length = 3'(rm_len);
         d.disp_size = rm_dsize;
         d.disp_value = rm_disp;
         // d bit: register operand is the destination
         if (opc[1]) begin
            d.dst_kind = KIND_REG;
            d.dst_select = {1'b0, regf};
            d.src_kind = rm_kind;
            d.src_select = rm_sel;
         end else begin
            d.dst_kind = rm_kind;
            d.dst_select = rm_sel;
            d.src_kind = KIND_REG;
            d.src_select = {1'b0, regf};
         end
         d.operand_wide = opc[0];
      end else if (opc[7:1] == PAT_IMM_MOV || (opc[7:2] == PAT_IMM_GRP &&
                   (regf == GRP_ADD || regf == GRP_SUB || regf == GRP_CMP))) begin
         if (opc[7:1] == PAT_IMM_MOV) begin
            d.operation = OP_MOV;
            imm16 = opc[0];
         end else begin
            d.operation = (regf == GRP_ADD) ? OP_ADD : (regf == GRP_SUB) ? OP_SUB : OP_CMP;
            // s bit set: one immediate byte, sign-extended
            imm16 = opc[0] && !opc[1];
         end
         d.dst_kind = rm_kind;
         d.dst_select = rm_sel;
         d.disp_size = rm_dsize;
         d.disp_value = rm_disp;
         d.src_kind = KIND_IMM;
         d.operand_wide = opc[0];
         imm_pos = rm_len;
      end else if (opc[7:4] == PAT_MOV_REG) begin
         d.operation = OP_MOV;
         d.dst_kind = KIND_REG;
         d.dst_select = {1'b0, opc[2:0]};
         d.src_kind = KIND_IMM;
         d.operand_wide = opc[3];
         imm16 = opc[3];
         imm_pos = 1;
      end else if (opc[7:1] == PAT_MOV_ACC_LD || opc[7:1] == PAT_MOV_ACC_ST) begin
         d.operation = OP_MOV;
         d.operand_wide = opc[0];
         if (opc[7:1] == PAT_MOV_ACC_LD) begin
            d.dst_kind = KIND_REG;
            d.dst_select = SEL_ACC;
            d.src_kind = KIND_IMM;
         end else begin
            d.dst_kind = KIND_IMM;
            d.src_kind = KIND_REG;
            d.src_select = SEL_ACC;
         end
         // the memory address is a full word whatever the width
         imm16 = 1'b1;
         imm_pos = 1;
      end else if (opc[7:1] == PAT_ACC_ADD || opc[7:1] == PAT_ACC_SUB ||
                   opc[7:1] == PAT_ACC_CMP) begin
         d.operation = (opc[7:1] == PAT_ACC_ADD) ? OP_ADD :
                       (opc[7:1] == PAT_ACC_SUB) ? OP_SUB : OP_CMP;
         d.dst_kind = KIND_REG;
         d.dst_select = SEL_ACC;
         d.src_kind = KIND_IMM;
         d.operand_wide = opc[0];
         imm16 = opc[0];
         imm_pos = 1;
      end else if (opc[7:4] == PAT_JCC || opc[7:2] == PAT_LOOP) begin
         if (opc[7:4] == PAT_JCC) begin
            d.operation = OP_JCC_BASE + 5'(opc[3:0]);
         end else begin
            case (opc)
               OPC_LOOP:   d.operation = OP_LOOP;
               OPC_LOOPZ:  d.operation = OP_LOOPZ;
               OPC_LOOPNZ: d.operation = OP_LOOPNZ;
               default:    d.operation = OP_JCXZ;
            endcase
         end
         d.dst_kind = KIND_REL;
         d.inst_length = 3'd2;
         rel = win[15:8] + 8'd2;
         d.imm_value = {{8{rel[7]}}, rel};
      end else begin
         d = '0;
         d.inst_length = 3'd1;
      end
      if (imm_pos != 0) begin
         d.imm_wide = imm16;
         d.imm_value = imm16 ? win[8*imm_pos +: 16] :
                       {{8{win[8*imm_pos+7]}}, win[8*imm_pos +: 8]};
         d.inst_length = 3'(imm_pos + (imm16 ? 2 : 1));
      end
      return d;
   endfunction

   // mostly well-formed windows with random content, some raw noise
   function automatic logic [WINDOW_W-1:0] random_window();
      logic [WINDOW_W-1:0] w;
      int unsigned         pick;
      w = {16'($urandom), 32'($urandom)};
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
         case ($urandom_range(0, 3))
            0:       w[7:2] = PAT_RM_MOV;
            1:       w[7:2] = PAT_RM_ADD;
            2:       w[7:2] = PAT_RM_SUB;
            default: w[7:2] = PAT_RM_CMP;
         endcase
      end else if (pick < 36) begin
         w[7:2] = PAT_IMM_GRP;
         if ($urandom_range(0, 6) != 0) begin
            case ($urandom_range(0, 2))
               0:       w[13:11] = GRP_ADD;
               1:       w[13:11] = GRP_SUB;
               default: w[13:11] = GRP_CMP;
            endcase
         end
      end else if (pick < 44) begin
         w[7:1] = PAT_IMM_MOV;
      end else if (pick < 54) begin
         w[7:4] = PAT_MOV_REG;
      end else if (pick < 62) begin
         w[7:1] = w[1] ? PAT_MOV_ACC_ST : PAT_MOV_ACC_LD;
      end else if (pick < 72) begin
         case ($urandom_range(0, 2))
            0:       w[7:1] = PAT_ACC_ADD;
            1:       w[7:1] = PAT_ACC_SUB;
            default: w[7:1] = PAT_ACC_CMP;
         endcase
      end else if (pick < 86) begin
         w[7:4] = PAT_JCC;
      end else if (pick < 92) begin
         w[7:2] = PAT_LOOP;
      end
      // direct addressing is rare in raw random modrm bytes
      if ($urandom_range(0, 7) == 0) begin
         w[15:14] = MOD_NODISP;
         w[10:8] = RM_DIRECT;
      end
      return w;
   endfunction

   // every so often a side runs back to back for a stretch
   function automatic int unsigned draw_gap(inout int unsigned burst_left);
      if (burst_left != 0) begin
         burst_left--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         burst_left = $urandom_range(8, 30);
         return 0;
      end
      return $urandom_range(0, 13);
   endfunction

   task automatic send_window(input logic [WINDOW_W-1:0] win, input logic typed,
                              input decoded_inst_type typed_want);
      int unsigned gap;
      gap = draw_gap(feed_burst);
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_inst_window <= win;
      do @(posedge clock); while (!req_ready);
      pending_decodes.push_back('{win, typed ? typed_want : decode_inst(win)});
      windows_sent++;
   endtask

   // hold the sender off until every outstanding item has come back
   task automatic hold_until_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_decodes.size() != 0) @(posedge clock);
   endtask

   task automatic check_field(input string name, input logic [WINDOW_W-1:0] win,
                              input logic [15:0] want, input logic [15:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t ns: window %h, %s expected %h, got %h",
                  $time, win, name, want, got);
      end
   endtask

   initial begin : stimulus
      reset = 1'b1;
      req_valid = 1'b0;
      req_inst_window = '0;
      windows_sent = 0;
      feed_burst = 0;
      // unknown encodings: everything clear but a length of one
      decode_cases[0]  = '{48'h0000_0000_000F, 1'b1, decoded(1'b0, OP_MOV, 3'd1, KIND_NONE,
                           4'd0, KIND_NONE, 4'd0, 1'b0, DSIZE_NONE, 16'h0, 1'b0, 16'h0)};
      decode_cases[1]  = '{48'h0000_0012_0880, 1'b1, decode_cases[0].want};
      decode_cases[2]  = '{48'h0000_0000_F083, 1'b1, decode_cases[0].want};
      decode_cases[3]  = '{48'hFFFF_FFFF_FFFF, 1'b1, decode_cases[0].want};
      decode_cases[4]  = '{48'h0000_0000_0000, 1'b0, '0};
      decode_cases[5]  = '{48'h0000_1234_068B, 1'b0, '0};
      decode_cases[6]  = '{48'h0000_0080_4703, 1'b0, '0};
      decode_cases[7]  = '{48'h0000_FFFF_9F2A, 1'b0, '0};
      decode_cases[8]  = '{48'h0000_0000_0039, 1'b0, '0};
      decode_cases[9]  = '{48'h0080_5678_06C6, 1'b0, '0};
      decode_cases[10] = '{48'hABCD_1234_86C7, 1'b0, '0};
      decode_cases[11] = '{48'h0000_1234_F8C7, 1'b0, '0};
      decode_cases[12] = '{48'h0000_8000_C081, 1'b0, '0};
      decode_cases[13] = '{48'h0000_00FF_EB83, 1'b0, '0};
      decode_cases[14] = '{48'h007F_0000_3E82, 1'b0, '0};
      decode_cases[15] = '{48'h0000_00FF_FFB8, 1'b1, decoded(1'b1, OP_MOV, 3'd3, KIND_REG,
                           SEL_ACC, KIND_IMM, 4'd0, 1'b1, DSIZE_NONE, 16'h0, 1'b1, 16'hFFFF)};
      decode_cases[16] = '{48'h0000_0012_34A0, 1'b0, '0};
      decode_cases[17] = '{48'h0000_00FF_FFA3, 1'b0, '0};
      decode_cases[18] = '{48'h0000_0000_FF04, 1'b0, '0};
      decode_cases[19] = '{48'h0000_0080_002D, 1'b0, '0};
      // jump and loop offsets, most of which wrap on the plus-two adjustment
      decode_cases[20] = '{48'h0000_0000_7E70, 1'b1, decoded(1'b1, OP_JCC_BASE, 3'd2, KIND_REL,
                           4'd0, KIND_NONE, 4'd0, 1'b0, DSIZE_NONE, 16'h0, 1'b0, 16'hFF80)};
      decode_cases[21] = '{48'h0000_0000_FF7F, 1'b1, decoded(1'b1, OP_JCC_BASE + 5'd15, 3'd2,
                           KIND_REL, 4'd0, KIND_NONE, 4'd0, 1'b0, DSIZE_NONE, 16'h0, 1'b0,
                           16'h0001)};
      decode_cases[22] = '{48'h0000_0000_FEE2, 1'b1, decoded(1'b1, OP_LOOP, 3'd2, KIND_REL,
                           4'd0, KIND_NONE, 4'd0, 1'b0, DSIZE_NONE, 16'h0, 1'b0, 16'h0000)};
      decode_cases[23] = '{48'h0000_0000_7FE1, 1'b0, '0};
      decode_cases[24] = '{48'h0000_0000_80E0, 1'b0, '0};
      decode_cases[25] = '{48'h0000_0000_00E3, 1'b0, '0};

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < N_DIRECTED; i++)
         send_window(decode_cases[i].window, decode_cases[i].typed, decode_cases[i].want);
      hold_until_drained();

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == RANDOM_ITEMS / 2)
            hold_until_drained();
         send_window(random_window(), 1'b0, '0);
      end
      hold_until_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("sent %0d windows (%0d hand-picked), checked %0d results, %0d unknown",
               windows_sent, N_DIRECTED, results_checked, unknown_seen);
      $display("operations decoded: %0d of 24, field mismatches: %0d",
               $countones(ops_seen), mismatches);
      if (mismatches == 0 && pending_decodes.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   initial begin : drain
      decoded_inst_type   got;
      pending_decode_type front;
      int unsigned        stall;
      rsp_ready = 1'b0;
      results_checked = 0;
      unknown_seen = 0;
      mismatches = 0;
      drain_burst = 0;
      ops_seen = '0;
      wait (!reset);
      forever begin
         stall = draw_gap(drain_burst);
         @(negedge clock);
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         got = '{rsp_known, rsp_operation, rsp_inst_length, rsp_dst_kind, rsp_dst_select,
                 rsp_src_kind, rsp_src_select, rsp_operand_wide, rsp_disp_size,
                 rsp_disp_value, rsp_imm_wide, rsp_imm_value};
         if (pending_decodes.size() == 0) begin
            mismatches++;
            $display("%0t ns: result item with nothing outstanding, expected none, got %h",
                     $time, got);
         end else begin
            front = pending_decodes.pop_front();
            check_field("known", front.window, 16'(front.want.known), 16'(got.known));
            check_field("operation", front.window, 16'(front.want.operation),
                        16'(got.operation));
            check_field("inst_length", front.window, 16'(front.want.inst_length),
                        16'(got.inst_length));
            check_field("dst_kind", front.window, 16'(front.want.dst_kind),
                        16'(got.dst_kind));
            check_field("dst_select", front.window, 16'(front.want.dst_select),
                        16'(got.dst_select));
            check_field("src_kind", front.window, 16'(front.want.src_kind),
                        16'(got.src_kind));
            check_field("src_select", front.window, 16'(front.want.src_select),
                        16'(got.src_select));
            check_field("operand_wide", front.window, 16'(front.want.operand_wide),
                        16'(got.operand_wide));
            check_field("disp_size", front.window, 16'(front.want.disp_size),
                        16'(got.disp_size));
            check_field("disp_value", front.window, front.want.disp_value, got.disp_value);
            check_field("imm_wide", front.window, 16'(front.want.imm_wide),
                        16'(got.imm_wide));
            check_field("imm_value", front.window, front.want.imm_value, got.imm_value);
            results_checked++;
            if (front.want.known)
               ops_seen[front.want.operation] = 1'b1;
            else
               unknown_seen++;
         end
      end
   end

   // ends the run if neither channel moves an item for too long
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("%0t ns: no item moved for %0d cycles", $time, STALL_LIMIT);
      $display("FAILURE");
      $finish;
   end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/x86dec_pkg.sv
hw/rtl/x86dec_modrm.sv
hw/rtl/x86_16bit_instruction_decoder_core.sv
verif/tb_x86_16bit_instruction_decoder_core.sv
